>>> sv/tlpr_pkg.sv
// Shared types, codes, constants and the color weighting function of the tile-map renderer.
`timescale 1ns / 1ps
package tlpr_pkg;

  localparam int unsigned CodeDepth    = 1024;
  localparam int unsigned ForePatDepth = 4096;
  localparam int unsigned BackPatDepth = 8192;
  localparam int unsigned PromDepth    = 64;

  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  typedef enum logic [RegIdxW-1:0] {
    REG_SCROLL_H    = 3'd0,
    REG_SCROLL_V    = 3'd1,
    REG_FLIP        = 3'd2,
    REG_BANK        = 3'd3,
    REG_BACK_COLOUR = 3'd4
  } tlpr_reg_e;

  typedef enum logic [2:0] {
    RGN_FORE_CODES = 3'd0,
    RGN_BACK_CODES = 3'd1,
    RGN_ATTRS      = 3'd2,
    RGN_FORE_PATS  = 3'd3,
    RGN_BACK_PATS  = 3'd4,
    RGN_PROM       = 3'd5
  } tlpr_region_e;

  // One pixel on its way from the PROM read to the result register.
  typedef struct packed {
    logic       valid;
    logic [5:0] idx;
  } tlpr_pix_t;

  // Resistor ladder: each PROM bit adds a fixed weight to its gun.
  function automatic logic [15:0] weigh_rgb565(input logic [7:0] p);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = (p[0] ? 8'h21 : 8'h00) + (p[1] ? 8'h47 : 8'h00) + (p[2] ? 8'h97 : 8'h00);
    g = (p[3] ? 8'h21 : 8'h00) + (p[4] ? 8'h47 : 8'h00) + (p[5] ? 8'h97 : 8'h00);
    b = (p[6] ? 8'h52 : 8'h00) + (p[7] ? 8'had : 8'h00);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

>>> sv/tlpr_ifs.sv
// Channel interfaces of the tile-map renderer: item input, result output and register writes.
`timescale 1ns / 1ps
interface tlpr_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [2:0]  region;
  logic [12:0] offset;
  logic [7:0]  load_byte;
  logic [7:0]  line;
  logic [7:0]  column;
  modport source (output valid, func, region, offset, load_byte, line, column, input ready);
  modport sink   (input valid, func, region, offset, load_byte, line, column, output ready);
endinterface

interface tlpr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_rgb565;
  logic [5:0]  palette_index;
  modport source (output valid, pixel_rgb565, palette_index, input ready);
  modport sink   (input valid, pixel_rgb565, palette_index, output ready);
endinterface

interface tlpr_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/tlpr_out_stage.sv
// Result register of the renderer: color weighting of the PROM byte and the pipeline advance.
`timescale 1ns / 1ps
module tlpr_out_stage
  import tlpr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tlpr_pix_t         pix_i,
  input  logic [7:0]        prom_byte_i,
  output logic              advance_o,
  tlpr_out_if.source        out_o
);

  logic        out_vld_q;
  logic        out_vld_d;
  logic [15:0] rgb_q;
  logic [5:0]  idx_q;

  // The whole pipeline moves whenever the result register is free or being emptied.
  assign advance_o = !out_vld_q || out_o.ready;
  assign out_vld_d = advance_o ? pix_i.valid : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && pix_i.valid) begin
      rgb_q <= weigh_rgb565(prom_byte_i);
      idx_q <= pix_i.idx;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.pixel_rgb565  = rgb_q;
  assign out_o.palette_index = idx_q;

endmodule

>>> sv/two_layer_tilemap_pixel_renderer_core.sv
// Top level of the two-layer tile-map pixel renderer: tile stores, pattern stores, PROM, pipeline.
//
//   channel  direction  what one beat carries
//   in_i     sink       load of one store byte, or one pixel to render
//   out_o    source     rendered RGB565 color and its PROM index
//   cfg_i    sink       one register write (index, data)
//
// One item is taken every cycle while the pipeline advances; a pixel reaches the result register
// after the chain of dependent registered memory reads: codes and attributes, then patterns,
// then the color PROM. Loads walk the same stages and write each store at the stage
// that reads it, so accesses stay in order. The stores have no reset and no clearing pass.
// While the result register holds a beat that is not taken, every stage holds and in_i stalls.
`timescale 1ns / 1ps
module two_layer_tilemap_pixel_renderer_core
  import tlpr_pkg::*;
#(
  parameter int unsigned VISIBLE_WIDTH = 224
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tlpr_in_if.sink    in_i,
  tlpr_cfg_if.sink   cfg_i,
  tlpr_out_if.source out_o
);

  localparam logic [8:0] VisWidth = 9'(VISIBLE_WIDTH);
  localparam logic [7:0] VisEnd   = 8'(VISIBLE_WIDTH - 1);

  // Configuration registers.
  logic [7:0] scroll_h_q;
  logic [7:0] scroll_v_q;
  logic       flip_q;
  logic       bank_q;
  logic [2:0] back_colour_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scroll_h_q    <= '0;
      scroll_v_q    <= '0;
      flip_q        <= 1'b0;
      bank_q        <= 1'b1;
      back_colour_q <= '0;
    end else if (cfg_i.valid) begin
      case (tlpr_reg_e'(cfg_i.index))
        REG_SCROLL_H:    scroll_h_q    <= cfg_i.data;
        REG_SCROLL_V:    scroll_v_q    <= cfg_i.data;
        REG_FLIP:        flip_q        <= cfg_i.data[0];
        REG_BANK:        bank_q        <= cfg_i.data[0];
        REG_BACK_COLOUR: back_colour_q <= cfg_i.data[2:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic in_acc;

  assign in_i.ready = en;
  assign in_acc     = in_i.valid && en;

  // Stage 0: screen to map coordinates, tile index, code and attribute reads.
  logic [7:0] sx;
  logic [7:0] sy;
  logic [7:0] bx;
  logic [7:0] by;
  logic [9:0] bti;
  logic [9:0] fti;
  logic       col_ok;
  logic       s0_load;
  logic       code_wr;

  assign sx      = flip_q ? ~in_i.line : in_i.line;
  assign sy      = flip_q ? in_i.column : (VisEnd - in_i.column);
  assign bx      = sx + scroll_h_q;
  assign by      = sy + scroll_v_q;
  assign bti     = {by[7:3], bx[7:3]};
  assign fti     = {sy[7:3], sx[7:3]};
  assign col_ok  = {1'b0, in_i.column} < VisWidth;
  assign s0_load = in_i.func == FUNC_LOAD;
  assign code_wr = in_acc && s0_load && (in_i.offset[12:10] == 3'd0);

  logic [7:0] fore_codes [CodeDepth];
  logic [7:0] back_codes [CodeDepth];
  logic [7:0] attr_mem   [CodeDepth];

  logic [7:0] fcode_q;
  logic [7:0] bcode_q;
  logic [7:0] fattr_q;
  logic [7:0] battr_q;

  always_ff @(posedge clk_i) begin
    if (code_wr && in_i.region == RGN_FORE_CODES) begin
      fore_codes[in_i.offset[9:0]] <= in_i.load_byte;
    end
    if (code_wr && in_i.region == RGN_BACK_CODES) begin
      back_codes[in_i.offset[9:0]] <= in_i.load_byte;
    end
    if (code_wr && in_i.region == RGN_ATTRS) begin
      attr_mem[in_i.offset[9:0]] <= in_i.load_byte;
    end
    if (en) begin
      fcode_q <= fore_codes[fti];
      bcode_q <= back_codes[bti];
      fattr_q <= attr_mem[fti];
      battr_q <= attr_mem[bti];
    end
  end

  logic        s1_vld_q;
  logic        s1_load_q;
  logic [2:0]  s1_region_q;
  logic [12:0] s1_offset_q;
  logic [7:0]  s1_byte_q;
  logic [2:0]  s1_brow_q;
  logic [2:0]  s1_bbit_q;
  logic [2:0]  s1_frow_q;
  logic [2:0]  s1_fbit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_acc && (s0_load || col_ok);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_load_q   <= s0_load;
      s1_region_q <= in_i.region;
      s1_offset_q <= in_i.offset;
      s1_byte_q   <= in_i.load_byte;
      s1_brow_q   <= by[2:0];
      s1_bbit_q   <= bx[2:0];
      s1_frow_q   <= sy[2:0];
      s1_fbit_q   <= sx[2:0];
    end
  end

  // Stage 1: pattern reads. Each pattern store is split on its top address bit, so the two
  // planes of a row are read from separate halves in the same cycle.
  logic [11:0] bbase;
  logic [10:0] fbase;
  logic        s1_ld;
  logic        fpat_wr;
  logic        bpat_wr;

  assign bbase   = {bank_q, bcode_q, s1_brow_q};
  assign fbase   = {fcode_q, s1_frow_q};
  assign s1_ld   = en && s1_vld_q && s1_load_q;
  assign fpat_wr = s1_ld && s1_region_q == RGN_FORE_PATS && !s1_offset_q[12];
  assign bpat_wr = s1_ld && s1_region_q == RGN_BACK_PATS;

  logic [7:0] fpat0_mem [ForePatDepth/2];
  logic [7:0] fpat1_mem [ForePatDepth/2];
  logic [7:0] bpat0_mem [BackPatDepth/2];
  logic [7:0] bpat1_mem [BackPatDepth/2];

  logic [7:0] fpat0_q;
  logic [7:0] fpat1_q;
  logic [7:0] bpat0_q;
  logic [7:0] bpat1_q;

  always_ff @(posedge clk_i) begin
    if (fpat_wr && !s1_offset_q[11]) begin
      fpat0_mem[s1_offset_q[10:0]] <= s1_byte_q;
    end
    if (fpat_wr && s1_offset_q[11]) begin
      fpat1_mem[s1_offset_q[10:0]] <= s1_byte_q;
    end
    if (bpat_wr && !s1_offset_q[12]) begin
      bpat0_mem[s1_offset_q[11:0]] <= s1_byte_q;
    end
    if (bpat_wr && s1_offset_q[12]) begin
      bpat1_mem[s1_offset_q[11:0]] <= s1_byte_q;
    end
    if (en) begin
      fpat0_q <= fpat0_mem[fbase];
      fpat1_q <= fpat1_mem[fbase];
      bpat0_q <= bpat0_mem[bbase];
      bpat1_q <= bpat1_mem[bbase];
    end
  end

  logic        s2_vld_q;
  logic        s2_load_q;
  logic [2:0]  s2_region_q;
  logic [12:0] s2_offset_q;
  logic [7:0]  s2_byte_q;
  logic [2:0]  s2_bbit_q;
  logic [2:0]  s2_fbit_q;
  logic [2:0]  s2_bgroup_q;
  logic [2:0]  s2_fgroup_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_load_q   <= s1_load_q;
      s2_region_q <= s1_region_q;
      s2_offset_q <= s1_offset_q;
      s2_byte_q   <= s1_byte_q;
      s2_bbit_q   <= s1_bbit_q;
      s2_fbit_q   <= s1_fbit_q;
      s2_bgroup_q <= battr_q[5:3];
      s2_fgroup_q <= fattr_q[2:0];
    end
  end

  // Stage 2: pixel selection and PROM read. Bit 7 of a pattern byte is the leftmost pixel.
  logic [2:0] bsel;
  logic [2:0] fsel;
  logic [1:0] bpix;
  logic [1:0] fpix;
  logic [5:0] idx;
  logic       prom_wr;

  assign bsel = ~s2_bbit_q;
  assign fsel = ~s2_fbit_q;
  assign bpix = {bpat0_q[bsel], bpat1_q[bsel]};
  assign fpix = {fpat0_q[fsel], fpat1_q[fsel]};

  always_comb begin
    if (fpix != 2'd0) begin
      idx = {1'b0, s2_fgroup_q, fpix};
    end else if (bpix != 2'd0) begin
      idx = {1'b1, s2_bgroup_q, bpix};
    end else begin
      idx = {1'b1, back_colour_q, 2'd0};
    end
  end

  assign prom_wr = en && s2_vld_q && s2_load_q && s2_region_q == RGN_PROM
                   && (s2_offset_q[12:6] == 7'd0);

  logic [7:0] prom_mem [PromDepth];
  logic [7:0] prom_q;

  always_ff @(posedge clk_i) begin
    if (prom_wr) begin
      prom_mem[s2_offset_q[5:0]] <= s2_byte_q;
    end
    if (en) begin
      prom_q <= prom_mem[idx];
    end
  end

  tlpr_pix_t s3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q <= '0;
    end else if (en) begin
      s3_q.valid <= s2_vld_q && !s2_load_q;
      s3_q.idx   <= idx;
    end
  end

  tlpr_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_i       (s3_q),
    .prom_byte_i (prom_q),
    .advance_o   (en),
    .out_o       (out_o)
  );

`ifndef SYNTHESIS
  // A result waiting at the output freezes the front of the pipeline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !in_i.ready)
    else $error("input accepted while the result register is blocked");

  // A pixel leaving stage 3 lands in the result register with its PROM index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && s3_q.valid) |=> (out_o.valid && out_o.palette_index == $past(s3_q.idx)))
    else $error("pixel lost between PROM read and result register");

  // Loads never make a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && !s3_q.valid) |=> !out_o.valid)
    else $error("result produced without a pixel in the last stage");

  // Stage contents hold while the pipeline is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(s3_q) && $stable(s2_vld_q) && $stable(s1_vld_q)))
    else $error("pipeline moved during a stall");
`endif

endmodule
